// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the voice allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME_CYCLE(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst_n, pre, post)
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, pre, post)
`endif
`endif

// ----- src/mva_pkg.sv -----
// Types, codes and the control program of the voice allocator.
package mva_pkg;

    localparam int NUM_VOICES_DEF = 22;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 7;
    localparam int STRIKE_W = 7;
    localparam int DV_W     = 5;
    localparam int ACT_W    = 2;
    localparam int VOICE_W  = 5;

    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
    localparam logic [OP_W-1:0] OP_DONE     = 2'd2;

    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] STEP_WAIT     = 3'd0;
    localparam logic [PC_W-1:0] STEP_DISPATCH = 3'd1;
    localparam logic [PC_W-1:0] STEP_SCAN     = 3'd2;
    localparam logic [PC_W-1:0] STEP_COMMIT   = 3'd3;
    localparam logic [PC_W-1:0] STEP_RETIRE   = 3'd4;

    localparam logic [1:0] COND_NO_BEAT   = 2'd0;
    localparam logic [1:0] COND_OP_HI     = 2'd1;
    localparam logic [1:0] COND_SCAN_MORE = 2'd2;
    localparam logic [1:0] COND_ALWAYS    = 2'd3;

    typedef struct packed {
        logic            wait_in;
        logic            scan;
        logic            commit;
        logic            retire;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic op_hi;
        logic scan_more;
    } stat_t;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [VOICE_W-1:0]  voice;
        logic [KEY_W-1:0]    out_key;
        logic [STRIKE_W-1:0] out_strike;
        logic                stolen;
    } res_t;

    // One control word per step; a taken condition jumps to target, else pc+1.
    function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctl_t w;
        w = '0;
        case (pc)
            STEP_WAIT:
            begin
                w.wait_in = 1'b1;
                w.cond    = COND_NO_BEAT;
                w.target  = STEP_WAIT;
            end
            STEP_DISPATCH:
            begin
                w.cond   = COND_OP_HI;
                w.target = STEP_RETIRE;
            end
            STEP_SCAN:
            begin
                w.scan   = 1'b1;
                w.cond   = COND_SCAN_MORE;
                w.target = STEP_SCAN;
            end
            STEP_COMMIT:
            begin
                w.commit = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
            STEP_RETIRE:
            begin
                w.retire = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- src/mva_sequencer.sv -----
// Step counter and control-word table of the voice allocator.
module mva_sequencer
    import mva_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  beat,
    input  stat_t stat,
    output ctl_t  ctl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctl = ucode_rom(pc_reg);

    always_comb
    begin
        case (ctl.cond)
            COND_NO_BEAT:   take = !beat;
            COND_OP_HI:     take = stat.op_hi;
            COND_SCAN_MORE: take = stat.scan_more;
            COND_ALWAYS:    take = 1'b1;
            default:        take = 1'b1;
        endcase
        pc_next = take ? ctl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- src/mva_datapath.sv -----
// Voice table, scan registers and result forming of the voice allocator.
module mva_datapath
    import mva_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat,
    input  logic [OP_W-1:0]     op,
    input  logic [KEY_W-1:0]    key,
    input  logic [STRIKE_W-1:0] strike,
    input  logic [DV_W-1:0]     done_voice,
    input  ctl_t                ctl,
    output stat_t               stat,
    output res_t                res
);

    localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);
    localparam logic [DV_W+1:0] NUM_WIDE = (DV_W + 2)'(NUM_VOICES);

    logic                active_reg [NUM_VOICES];
    logic                active_next [NUM_VOICES];
    logic                gate_reg [NUM_VOICES];
    logic                gate_next [NUM_VOICES];
    logic [KEY_W-1:0]    vkey_reg [NUM_VOICES];
    logic [KEY_W-1:0]    vkey_next [NUM_VOICES];

    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [STRIKE_W-1:0] strike_reg, strike_next;
    logic [DV_W-1:0]     dv_reg, dv_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic                free_reg, free_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;

    logic [DV_W+1:0]     dv_wide;
    logic [IDX_W-1:0]    pick;

    assign stat.op_hi     = op_reg[1];
    assign stat.scan_more = (idx_reg != LAST_IDX);
    assign dv_wide        = (DV_W + 2)'(dv_reg);

    always_comb
    begin
        active_next   = active_reg;
        gate_next     = gate_reg;
        vkey_next     = vkey_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        strike_next   = strike_reg;
        dv_next       = dv_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        res           = '0;
        pick          = '0;

        if (beat)
        begin
            op_next     = op;
            key_next    = key;
            strike_next = strike;
            dv_next     = done_voice;
            idx_next    = '0;
            hit_next    = 1'b0;
            free_next   = 1'b0;
        end

        // One voice per step: remember the first holder of the key and the first idle voice.
        if (ctl.scan)
        begin
            if (!hit_reg && active_reg[idx_reg] && (vkey_reg[idx_reg] == key_reg))
            begin
                hit_next     = 1'b1;
                hit_idx_next = idx_reg;
            end
            if (!free_reg && !active_reg[idx_reg])
            begin
                free_next     = 1'b1;
                free_idx_next = idx_reg;
            end
            idx_next = idx_reg + 1'b1;
        end

        if (ctl.commit)
        begin
            if ((op_reg == OP_NOTE_ON) && (strike_reg != '0))
            begin
                if (hit_reg)
                begin
                    pick = hit_idx_reg;
                end
                else if (free_reg)
                begin
                    pick = free_idx_reg;
                end
                else
                begin
                    pick = '0;
                end
                active_next[pick] = 1'b1;
                gate_next[pick]   = 1'b1;
                vkey_next[pick]   = key_reg;
                res.action     = ACT_START;
                res.voice      = VOICE_W'(pick);
                res.out_key    = key_reg;
                res.out_strike = strike_reg;
                res.stolen     = !hit_reg && !free_reg;
            end
            else if (hit_reg)
            begin
                gate_next[hit_idx_reg] = 1'b0;
                res.action  = ACT_RELEASE;
                res.voice   = VOICE_W'(hit_idx_reg);
                res.out_key = key_reg;
            end
        end

        if (ctl.retire)
        begin
            if ((op_reg == OP_DONE) && (dv_wide < NUM_WIDE))
            begin
                active_next[dv_wide[IDX_W-1:0]] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                active_reg[i] <= 1'b0;
                gate_reg[i]   <= 1'b0;
                vkey_reg[i]   <= '0;
            end
            idx_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            gate_reg   <= gate_next;
            vkey_reg   <= vkey_next;
            idx_reg    <= idx_next;
            hit_reg    <= hit_next;
            free_reg   <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        strike_reg   <= strike_next;
        dv_reg       <= dv_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

endmodule

// ----- src/midi_voice_allocator.sv -----
// Top level of the MIDI voice allocator: stream ports, output register, checks.
//
// The input stream carries one MIDI event per beat: the operation code in tuser
// and key, velocity and finished-voice index in tdata. Every accepted event
// produces exactly one result beat on the output stream: an action code in
// tuser and voice index, key, velocity and the steal flag in tdata.
// Control is a five-step program: wait, dispatch, one scan step per voice,
// then commit or retire. A note-on or note-off event passes through dispatch,
// the scan and commit before its result is loaded; a voice-done event or an
// unused code goes from dispatch straight to retire. The scan covers the
// voice table one entry per cycle. The next event is accepted at the wait
// step that follows commit or retire, so the block handles one event at a
// time.
// Reset clears all voice flags and returns the program to its wait step.
// The result waits in an output register while the receiver stalls; a new
// event is accepted only once that register is free or being emptied.
`include "assert_macros.svh"

module midi_voice_allocator
    import mva_pkg::*;
#(
    parameter int NUM_VOICES = NUM_VOICES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // key[6:0], strike[13:7], done_voice[18:14], zero fill
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // voice[4:0], out_key[11:5], out_strike[18:12],
                                       // stolen[19], zero fill
    output logic [1:0]  m_axis_tuser   // action[1:0]
);

    ctl_t  ctl;
    stat_t stat;
    res_t  res;
    logic  beat;
    logic  load;

    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;

    // An event may enter while a finished result is leaving in the same cycle.
    assign s_axis_tready = ctl.wait_in && (!out_valid_reg || m_axis_tready);
    assign beat          = s_axis_tvalid && s_axis_tready;
    assign load          = ctl.commit || ctl.retire;

    mva_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .stat  (stat),
        .ctl   (ctl)
    );

    mva_datapath #(
        .NUM_VOICES (NUM_VOICES)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .op         (s_axis_tuser),
        .key        (s_axis_tdata[6:0]),
        .strike     (s_axis_tdata[13:7]),
        .done_voice (s_axis_tdata[18:14]),
        .ctl        (ctl),
        .stat       (stat),
        .res        (res)
    );

    // The result register is loaded at the last step of the program and held
    // until the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.action;
    assign m_axis_tdata  = {4'b0, out_reg.stolen, out_reg.out_strike,
                            out_reg.out_key, out_reg.voice};

    // The program leaves its wait step right after taking an event.
    `ASSERT_NEXT_CYCLE(a_busy_after_beat, clk, rst_n, beat, !s_axis_tready)
    // A new result never overwrites one that is still pending.
    `ASSERT_SAME_CYCLE(a_no_overwrite, clk, rst_n, load, !out_valid_reg)
    // A steal always starts voice 0.
    `ASSERT_SAME_CYCLE(a_steal_voice0, clk, rst_n, m_axis_tvalid && out_reg.stolen,
        (out_reg.voice == '0) && (out_reg.action == ACT_START))

endmodule
